### src/imu_tcf_pkg.sv
package imu_tcf_pkg;

    // iteration count of the shared cordic unit, 8 to 24
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    // fixed widths of the datapath
    localparam int CX_W  = 28;     // cordic x and y
    localparam int CZ_W  = 27;     // cordic angle accumulator
    localparam int CNT_W = 5;      // iteration counter
    localparam int SQ_ITERS  = 24; // root bits
    localparam int DIV_ITERS = 25; // quotient bits of the gyro step

    // angle constants in q16.16 degrees, unity blend weight with 16 fraction bits, dt limit in us
    localparam logic signed [CZ_W-1:0] DEG180      = 27'sd11796480;
    localparam logic signed [29:0]     ANGLE_LIMIT = 30'sd23592960;
    localparam logic signed [20:0]     OFFSET_LIMIT = 21'sd655360;
    localparam logic [16:0]            WEIGHT_ONE  = 17'd65536;
    localparam logic [19:0]            DT_MAX_US   = 20'd1000000;

    // gyro scale divisor, 131 lsb per deg/s times 1e6 us, and half of it
    localparam logic [27:0] GYRO_DIV  = 28'd131000000;
    localparam logic [51:0] GYRO_HALF = 52'd65500000;

    // config register indexes
    localparam logic [7:0] REG_BLEND_WEIGHT = 8'd0;
    localparam logic [7:0] REG_ANGLE_OFFSET = 8'd1;

    // atan(2^-i) in q16.16 degrees, rounded to nearest
    function automatic logic [21:0] atan_q16(input logic [CNT_W-1:0] idx);
        logic [21:0] r;
        case (idx)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

### src/imu_tilt_complementary_filter.sv
// Complementary tilt filter: one IMU sample per input transaction gives one result
// transaction with roll, pitch and tilt in q16.16 degrees. The first prep state forms products
// and sets up the shared cordic unit, and the second prep state sets up the divide and the
// square root. Then come 25 bit-serial steps of the gyro divide, with the square root steps,
// while the cordic unit resolves roll. One state sets up pitch, which then takes
// CORDIC_STEPS steps. A multiply state and a sum, round and saturate state finish the blend.
// The input stalls from acceptance until the result register is loaded, so a new sample is
// taken only once the last result is loaded, and later while the output stalls.
module imu_tilt_complementary_filter
    import imu_tcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [20:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic [19:0]        elapsed_us,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [25:0] roll_deg,
    output logic signed [25:0] pitch_deg,
    output logic signed [25:0] tilt_deg
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_PREP2, S_ITER, S_PINIT, S_PCORD, S_BL1, S_BL2
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic out_valid_reg;
    logic [16:0] weight_reg;
    logic signed [20:0] offset_reg;
    logic signed [25:0] roll_est_reg, pitch_est_reg;

    // sample registers
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [19:0] dt_reg;

    // prep products
    logic [31:0] sq_reg;
    logic signed [36:0] prod_r_reg, prod_p_reg;

    // bit-serial dividers and square root
    logic [26:0] drem_r_reg, drem_p_reg;
    logic [24:0] dnum_r_reg, dnum_p_reg;
    logic neg_r_reg, neg_p_reg;
    logic [47:0] sqn_reg;
    logic [25:0] srem_reg;
    logic [23:0] root_reg;

    // shared cordic unit
    logic signed [CX_W-1:0] cx_reg, cy_reg;
    logic signed [CZ_W-1:0] cz_reg;
    logic zero_r_reg, zero_p_reg;
    logic signed [CZ_W-1:0] roll_acc_reg;

    // blend products
    logic signed [44:0] mr1_reg, mr2_reg, mp1_reg, mp2_reg;

    logic signed [25:0] roll_out_reg, pitch_out_reg, tilt_out_reg;

    logic in_acc, out_acc, out_free;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_acc   = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign roll_deg  = roll_out_reg;
    assign pitch_deg = pitch_out_reg;
    assign tilt_deg  = tilt_out_reg;

    // cordic step
    logic signed [CX_W-1:0] cx_next, cy_next, xs, ys;
    logic signed [CZ_W-1:0] cz_next;
    logic signed [CZ_W-1:0] atan_s;
    always_comb
    begin
        xs = cx_reg >>> cnt_reg;
        ys = cy_reg >>> cnt_reg;
        atan_s = $signed({5'b0, atan_q16(cnt_reg)});
        if (cy_reg > 0)
        begin
            cx_next = cx_reg + ys;
            cy_next = cy_reg - xs;
            cz_next = cz_reg + atan_s;
        end
        else
        begin
            cx_next = cx_reg - ys;
            cy_next = cy_reg + xs;
            cz_next = cz_reg - atan_s;
        end
    end

    // divider steps, one quotient bit each
    logic [27:0] drem2_r, drem2_p;
    logic dge_r, dge_p;
    logic [26:0] drem_r_next, drem_p_next;
    always_comb
    begin
        drem2_r = {drem_r_reg, dnum_r_reg[24]};
        drem2_p = {drem_p_reg, dnum_p_reg[24]};
        dge_r = (drem2_r >= GYRO_DIV);
        dge_p = (drem2_p >= GYRO_DIV);
        drem_r_next = dge_r ? 27'(drem2_r - GYRO_DIV) : drem2_r[26:0];
        drem_p_next = dge_p ? 27'(drem2_p - GYRO_DIV) : drem2_p[26:0];
    end

    // square root step, one root bit each
    logic [27:0] srem2, strial;
    logic sge;
    always_comb
    begin
        srem2  = {srem_reg, sqn_reg[47:46]};
        strial = {2'b0, root_reg, 2'b01};
        sge    = (srem2 >= strial);
    end

    // prep values
    logic signed [CX_W-1:0] rx0, ry0, py0;
    logic [35:0] mag_r, mag_p;
    logic [51:0] num_r, num_p;
    always_comb
    begin
        rx0 = $signed({{4{az_reg[15]}}, az_reg, 8'b0});
        ry0 = $signed({{4{ay_reg[15]}}, ay_reg, 8'b0});
        py0 = -$signed({{4{ax_reg[15]}}, ax_reg, 8'b0});
        mag_r = prod_r_reg[36] ? 36'(-prod_r_reg) : prod_r_reg[35:0];
        mag_p = prod_p_reg[36] ? 36'(-prod_p_reg) : prod_p_reg[35:0];
        num_r = {mag_r, 16'b0} + GYRO_HALF;
        num_p = {mag_p, 16'b0} + GYRO_HALF;
    end

    // blend inputs
    logic signed [25:0] delta_r, delta_p;
    logic signed [26:0] gpath_r, gpath_p, pacc_sel;
    logic signed [17:0] w_s, wc_s;
    always_comb
    begin
        delta_r = neg_r_reg ? -$signed({1'b0, dnum_r_reg}) : $signed({1'b0, dnum_r_reg});
        delta_p = neg_p_reg ? -$signed({1'b0, dnum_p_reg}) : $signed({1'b0, dnum_p_reg});
        gpath_r = 27'(roll_est_reg) + 27'(delta_r);
        gpath_p = 27'(pitch_est_reg) + 27'(delta_p);
        pacc_sel = zero_p_reg ? '0 : cz_reg;
        w_s  = $signed({1'b0, weight_reg});
        wc_s = $signed({1'b0, 17'(WEIGHT_ONE - weight_reg)});
    end

    // final sum, rounding and saturation
    logic signed [45:0] sum_r, sum_p;
    logic signed [29:0] sh_r, sh_p;
    logic signed [25:0] roll_next, pitch_next, tilt_next;
    always_comb
    begin
        sum_r = 46'(mr1_reg) + 46'(mr2_reg) + 46'sd32768;
        sum_p = 46'(mp1_reg) + 46'(mp2_reg) + 46'sd32768;
        sh_r = 30'(sum_r >>> 16);
        sh_p = 30'(sum_p >>> 16);
        if (sh_r > ANGLE_LIMIT)       roll_next = 26'(ANGLE_LIMIT);
        else if (sh_r < -ANGLE_LIMIT) roll_next = 26'(-ANGLE_LIMIT);
        else                          roll_next = sh_r[25:0];
        if (sh_p > ANGLE_LIMIT)       pitch_next = 26'(ANGLE_LIMIT);
        else if (sh_p < -ANGLE_LIMIT) pitch_next = 26'(-ANGLE_LIMIT);
        else                          pitch_next = sh_p[25:0];
        tilt_next = roll_next + 26'(offset_reg);
    end

    // config writes
    logic signed [20:0] cfg_off;
    always_comb
    begin
        cfg_off = $signed(cfg_data);
    end

    // sequencer, config and estimates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            weight_reg    <= 17'd64225;
            offset_reg    <= 21'sd150733;
            roll_est_reg  <= '0;
            pitch_est_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BLEND_WEIGHT)
                    weight_reg <= (cfg_data[16:0] > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data[16:0];
                else if (cfg_index == REG_ANGLE_OFFSET)
                begin
                    if (cfg_off > OFFSET_LIMIT)       offset_reg <= OFFSET_LIMIT;
                    else if (cfg_off < -OFFSET_LIMIT) offset_reg <= -OFFSET_LIMIT;
                    else                              offset_reg <= cfg_off;
                end
            end
            // result taken, unless a new one is loaded in the same cycle
            if (out_acc && (state_reg != S_BL2))
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_acc)
                        state_reg <= S_PREP;
                S_PREP:
                    state_reg <= S_PREP2;
                S_PREP2:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (cnt_reg == CNT_W'(DIV_ITERS - 1))
                        state_reg <= S_PINIT;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_PINIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_PCORD;
                end
                S_PCORD:
                begin
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                        state_reg <= S_BL1;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_BL1:
                    state_reg <= S_BL2;
                S_BL2:
                    if (out_free)
                    begin
                        roll_est_reg  <= roll_next;
                        pitch_est_reg <= pitch_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    ax_reg <= accel_x;
                    ay_reg <= accel_y;
                    az_reg <= accel_z;
                    gx_reg <= gyro_x;
                    gy_reg <= gyro_y;
                    dt_reg <= (elapsed_us > DT_MAX_US) ? DT_MAX_US : elapsed_us;
                end
            S_PREP:
            begin
                sq_reg <= 32'(ay_reg * ay_reg) + 32'(az_reg * az_reg);
                prod_r_reg <= gx_reg * $signed({1'b0, dt_reg});
                prod_p_reg <= gy_reg * $signed({1'b0, dt_reg});
                zero_r_reg <= (ay_reg == '0) && (az_reg == '0);
                if (az_reg < 0)
                begin
                    cx_reg <= -rx0;
                    cy_reg <= -ry0;
                    cz_reg <= (ay_reg >= 0) ? DEG180 : -DEG180;
                end
                else
                begin
                    cx_reg <= rx0;
                    cy_reg <= ry0;
                    cz_reg <= '0;
                end
            end
            S_PREP2:
            begin
                drem_r_reg <= num_r[51:25];
                dnum_r_reg <= num_r[24:0];
                neg_r_reg  <= prod_r_reg[36];
                drem_p_reg <= num_p[51:25];
                dnum_p_reg <= num_p[24:0];
                neg_p_reg  <= prod_p_reg[36];
                sqn_reg    <= {sq_reg, 16'b0};
                srem_reg   <= '0;
                root_reg   <= '0;
            end
            S_ITER:
            begin
                drem_r_reg <= drem_r_next;
                dnum_r_reg <= {dnum_r_reg[23:0], dge_r};
                drem_p_reg <= drem_p_next;
                dnum_p_reg <= {dnum_p_reg[23:0], dge_p};
                if (cnt_reg < CNT_W'(SQ_ITERS))
                begin
                    sqn_reg  <= {sqn_reg[45:0], 2'b00};
                    srem_reg <= sge ? 26'(srem2 - strial) : srem2[25:0];
                    root_reg <= {root_reg[22:0], sge};
                end
                if (cnt_reg < CNT_W'(CORDIC_STEPS))
                begin
                    cx_reg <= cx_next;
                    cy_reg <= cy_next;
                    cz_reg <= cz_next;
                end
            end
            S_PINIT:
            begin
                roll_acc_reg <= zero_r_reg ? '0 : cz_reg;
                zero_p_reg   <= (ax_reg == '0) && (root_reg == '0);
                cx_reg <= $signed({4'b0, root_reg});
                cy_reg <= py0;
                cz_reg <= '0;
            end
            S_PCORD:
            begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                cz_reg <= cz_next;
            end
            S_BL1:
            begin
                mr1_reg <= w_s * gpath_r;
                mr2_reg <= wc_s * roll_acc_reg;
                mp1_reg <= w_s * gpath_p;
                mp2_reg <= wc_s * pacc_sel;
            end
            S_BL2:
                if (out_free)
                begin
                    roll_out_reg  <= roll_next;
                    pitch_out_reg <= pitch_next;
                    tilt_out_reg  <= tilt_next;
                end
            default:
            begin
            end
        endcase
    end

endmodule
